// ===== design/segment_display_buffer_macros.svh =====
// ----------------------------------------------------------------------------
// Segment display buffer assertion macros
// Shared concurrent assertion helpers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_DISPLAY_BUFFER_MACROS_SVH
`define SEGMENT_DISPLAY_BUFFER_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled during reset
`define SDB_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("segment display buffer assertion failed");

// Next-cycle implication, disabled during reset
`define SDB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("segment display buffer assertion failed");

`else

`define SDB_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SDB_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== design/sdb_pkg.sv =====
// ----------------------------------------------------------------------------
// Segment display buffer package
// Field widths, command codes, segment constants and the digit glyph table.
// ----------------------------------------------------------------------------
package sdb_pkg;

  // Field and bus widths
  localparam int OpcodeW   = 3;
  localparam int ValueW    = 17;
  localparam int PositionW = 3;
  localparam int CodeW     = 8;
  localparam int SegW      = 8;
  localparam int NumSegs   = 6;
  localparam int MagW      = 11;
  localparam int InDataW   = 32;
  localparam int ResultW   = 1 + NumSegs * SegW;
  localparam int OutDataW  = 56;
  localparam int OutPadW   = OutDataW - ResultW;

  typedef enum logic [OpcodeW-1:0] {
    OP_BIG       = 3'd0,
    OP_SMALL     = 3'd1,
    OP_DIGIT     = 3'd2,
    OP_UNIT      = 3'd3,
    OP_BLUETOOTH = 3'd4,
    OP_BATTERY   = 3'd5,
    OP_SMILEY    = 3'd6,
    OP_READ      = 3'd7
  } opcode_t;

  // One command; opcode sits in the lowest bits, code in the highest
  typedef struct packed {
    logic [CodeW-1:0]         code;
    logic [PositionW-1:0]     position;
    logic                     flag;
    logic signed [ValueW-1:0] value;
    opcode_t                  opcode;
  } cmd_t;

  typedef logic [SegW-1:0]        seg_t;
  typedef seg_t [NumSegs-1:0]     image_t;

  // Image after a command, image byte 0 in the lowest bits
  typedef struct packed {
    logic   accepted;
    image_t image;
  } result_t;

  // Segment byte roles
  localparam int SegSmallUnits = 0;
  localparam int SegSmallTens  = 1;
  localparam int SegSymbols    = 2;
  localparam int SegBigUnits   = 3;
  localparam int SegBigTens    = 4;
  localparam int SegBigHigh    = 5;

  // Bit patterns
  localparam seg_t DigitMask   = 8'hF7;
  localparam seg_t SymbolBit   = 8'h08;
  localparam seg_t MinusBits   = 8'h02;
  localparam seg_t UnitMask    = 8'hE0;
  localparam seg_t UnitCBits   = 8'hA0;
  localparam seg_t UnitFBits   = 8'h60;
  localparam seg_t BtBit       = 8'h10;
  localparam seg_t SmileyMask  = 8'h07;
  localparam seg_t HappyBits   = 8'h05;
  localparam seg_t SadBits     = 8'h06;

  // Symbol selector codes
  localparam logic [CodeW-1:0] CodeUnitC = 8'd1;
  localparam logic [CodeW-1:0] CodeUnitF = 8'd2;
  localparam logic [CodeW-1:0] CodeHappy = 8'd1;
  localparam logic [CodeW-1:0] CodeSad   = 8'd2;

  // Number ranges
  localparam logic signed [ValueW-1:0] BigMax      = 17'sd1999;
  localparam logic signed [ValueW-1:0] BigMin      = -17'sd99;
  localparam logic signed [ValueW-1:0] LeadOneMin  = 17'sd1000;
  localparam logic signed [ValueW-1:0] SmallMax    = 17'sd99;
  localparam logic signed [ValueW-1:0] DigitMax    = 17'sd9;
  localparam logic [MagW-1:0]          MagTensMin  = 11'd10;
  localparam logic [MagW-1:0]          MagHundMin  = 11'd100;

  // Reciprocals for the digit split, exact for magnitudes below 2048
  localparam int RecipShift = 19;
  localparam int Recip10    = 52429;
  localparam int Recip100   = 5243;

  // Seven-segment glyph of a decimal digit, symbol bit kept clear
  function automatic seg_t glyph(input logic [3:0] digit);
    seg_t pattern;
    case (digit)
      4'd0:    pattern = 8'hF5;
      4'd1:    pattern = 8'h05;
      4'd2:    pattern = 8'hD3;
      4'd3:    pattern = 8'h97;
      4'd4:    pattern = 8'h27;
      4'd5:    pattern = 8'hB6;
      4'd6:    pattern = 8'hF6;
      4'd7:    pattern = 8'h15;
      4'd8:    pattern = 8'hF7;
      4'd9:    pattern = 8'hB7;
      default: pattern = 8'h00;
    endcase
    return pattern & DigitMask;
  endfunction

endpackage

// ===== design/segment_display_buffer.sv =====
// ----------------------------------------------------------------------------
// Segment display buffer
// Holds a six-byte LCD segment image and updates it from one command per
// transfer, returning the full image and an accepted flag for each command.
//
// Input stream s_axis carries one command per transfer. Output stream
// m_axis returns one result per command, in order.
// A command taken on s_axis passes the input register, then the result
// register, before its result shows on m_axis. Throughput: one command
// per cycle unless the receiver stalls; the image update is a single
// read-modify-write of the image register between the two registers.
// Reset clears the image to all zeros and empties both registers.
// When the receiver stalls, the result register holds its transfer and
// the input register still takes one more command; s_axis_tready then
// drops until the result is taken.
// ----------------------------------------------------------------------------
`include "segment_display_buffer_macros.svh"

module segment_display_buffer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // opcode[2:0], value[19:3], flag[20], position[23:21], code[31:24]
  input  logic [sdb_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // seg0[7:0], seg1[15:8], seg2[23:16], seg3[31:24], seg4[39:32],
  // seg5[47:40], accepted[48], zero pad [55:49]
  output logic [sdb_pkg::OutDataW-1:0]   m_axis_tdata
);
  import sdb_pkg::*;

  logic    in_valid;
  cmd_t    cmd;
  image_t  image;
  logic    out_valid;
  result_t out_result;
  result_t upd;
  logic    advance;

  // Move the held command into the result register when there is room
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {OutPadW'(0), out_result};

  sdb_update u_update (
    .cmd    (cmd),
    .image  (image),
    .result (upd)
  );

  // Control state and the display image
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      image     <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (advance) begin
        image     <= upd.image;
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Capture command and result payloads
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd <= cmd_t'(s_axis_tdata);
    end
    if (advance) begin
      out_result <= upd;
    end
  end

  // Image changes only when a command is applied
  `SDB_ASSERT_NEXT(a_image_hold, clk, rst, !advance, $stable(image))
  // A rejected command leaves the image alone
  `SDB_ASSERT_NEXT(a_reject_hold, clk, rst, advance && !upd.accepted, $stable(image))
  // Symbol byte is touched only by the symbol commands
  `SDB_ASSERT_NEXT(a_symbol_hold, clk, rst,
    advance && cmd.opcode != OP_UNIT && cmd.opcode != OP_BLUETOOTH &&
    cmd.opcode != OP_SMILEY && cmd.opcode != OP_DIGIT,
    $stable(image[SegSymbols]))
  // A pending result always shows the current image
  `SDB_ASSERT_IMPL(a_result_image, clk, rst, out_valid, out_result.image == image)

endmodule

// ===== design/sdb_update.sv =====
// ----------------------------------------------------------------------------
// Segment display buffer image update
// Applies one command to the current image and reports whether it was taken.
// ----------------------------------------------------------------------------
module sdb_update (
  input  sdb_pkg::cmd_t    cmd,
  input  sdb_pkg::image_t  image,
  output sdb_pkg::result_t result
);
  import sdb_pkg::*;

  logic [ValueW-1:0]      neg_value;
  logic [MagW-1:0]        mag;
  logic [MagW+15:0]       prod10;
  logic [MagW+12:0]       prod100;
  logic [7:0]             q10;
  logic [4:0]             q100;
  logic [MagW-1:0]        units_wide;
  logic [7:0]             tens_wide;
  logic [4:0]             hund_wide;
  logic [3:0]             units;
  logic [3:0]             tens;
  logic [3:0]             hund;
  logic                   is_neg;
  logic                   big_ok;
  logic                   small_ok;
  logic                   digit_ok;
  seg_t                   big_high;
  seg_t                   big_tens;
  seg_t                   small_units;
  seg_t                   small_tens;

  // Magnitude of the number; only the in-range cases use it
  assign is_neg    = cmd.value[ValueW-1];
  assign neg_value = -cmd.value;
  assign mag       = is_neg ? neg_value[MagW-1:0] : cmd.value[MagW-1:0];

  // Split into decimal digits by reciprocal multiplication
  assign prod10     = {16'd0, mag} * (MagW+16)'(Recip10);
  assign prod100    = {13'd0, mag} * (MagW+13)'(Recip100);
  assign q10        = prod10[RecipShift +: 8];
  assign q100       = prod100[RecipShift +: 5];
  assign units_wide = mag - MagW'(q10) * MagW'(10);
  assign tens_wide  = q10 - 8'(q100) * 8'd10;
  assign hund_wide  = (q100 >= 5'd10) ? q100 - 5'd10 : q100;
  assign units      = units_wide[3:0];
  assign tens       = tens_wide[3:0];
  assign hund       = hund_wide[3:0];

  // Range checks
  assign big_ok   = (cmd.value <= BigMax) && (cmd.value >= BigMin);
  assign small_ok = !is_neg && (cmd.value <= SmallMax);
  assign digit_ok = !is_neg && (cmd.value <= DigitMax) &&
                    (cmd.position <= PositionW'(SegBigHigh)) &&
                    (cmd.position != PositionW'(SegSymbols));

  // Build the number bytes
  always_comb begin
    if (is_neg) begin
      big_high = MinusBits;
    end else if (cmd.value >= LeadOneMin) begin
      big_high = SymbolBit;
    end else begin
      big_high = '0;
    end
    if (mag >= MagHundMin) begin
      big_high = big_high | glyph(hund);
    end
    // tens digit reads zero below ten, so it always draws
    big_tens    = (cmd.flag ? SymbolBit : seg_t'(0)) | glyph(tens);
    small_units = (cmd.flag ? SymbolBit : seg_t'(0)) | glyph(units);
    small_tens  = image[SegSmallTens] & SymbolBit;
    if (mag >= MagTensMin) begin
      small_tens = small_tens | glyph(tens);
    end
  end

  // Apply the command
  always_comb begin
    result.image    = image;
    result.accepted = 1'b1;
    case (cmd.opcode)
      OP_BIG: begin
        if (big_ok) begin
          result.image[SegBigHigh]  = big_high;
          result.image[SegBigTens]  = big_tens;
          result.image[SegBigUnits] = glyph(units);
        end else begin
          result.accepted = 1'b0;
        end
      end
      OP_SMALL: begin
        if (small_ok) begin
          result.image[SegSmallUnits] = small_units;
          result.image[SegSmallTens]  = small_tens;
        end else begin
          result.accepted = 1'b0;
        end
      end
      OP_DIGIT: begin
        if (digit_ok) begin
          for (int i = 0; i < NumSegs; i++) begin
            if (cmd.position == PositionW'(i)) begin
              result.image[i] = glyph(units);
            end
          end
        end else begin
          result.accepted = 1'b0;
        end
      end
      OP_UNIT: begin
        result.image[SegSymbols] = image[SegSymbols] & ~UnitMask;
        if (cmd.code == CodeUnitC) begin
          result.image[SegSymbols] = result.image[SegSymbols] | UnitCBits;
        end else if (cmd.code == CodeUnitF) begin
          result.image[SegSymbols] = result.image[SegSymbols] | UnitFBits;
        end
      end
      OP_BLUETOOTH: begin
        if (cmd.code != '0) begin
          result.image[SegSymbols] = image[SegSymbols] | BtBit;
        end else begin
          result.image[SegSymbols] = image[SegSymbols] & ~BtBit;
        end
      end
      OP_BATTERY: begin
        if (cmd.code != '0) begin
          result.image[SegSmallTens] = image[SegSmallTens] | SymbolBit;
        end else begin
          result.image[SegSmallTens] = image[SegSmallTens] & ~SymbolBit;
        end
      end
      OP_SMILEY: begin
        result.image[SegSymbols] = image[SegSymbols] & ~SmileyMask;
        if (cmd.code == CodeHappy) begin
          result.image[SegSymbols] = result.image[SegSymbols] | HappyBits;
        end else if (cmd.code == CodeSad) begin
          result.image[SegSymbols] = result.image[SegSymbols] | SadBits;
        end
      end
      OP_READ: begin
        result.accepted = 1'b1;
      end
      default: begin
        result.accepted = 1'b1;
      end
    endcase
  end

endmodule
